/* src/m3i_pkg.sv */
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int EB = 32;                  // element width
   localparam int FB = 16;                  // fraction bits
   localparam int NC = 9;                   // elements per matrix
   localparam int PW = 2 * EB;              // element product
   localparam int CW = 2 * EB + 1;          // cofactor
   localparam int DW = 3 * EB + 2;          // determinant
   localparam int RW_A = DW + EB + 2;
   localparam int RW_B = 2 * EB + 2 * FB + 3;
   localparam int RW = (RW_A > RW_B) ? RW_A : RW_B;   // divider datapath
   localparam int QW = EB + 1;              // quotient bits kept

   // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], already transposed (adjugate order)
   localparam logic [3:0] COF_IDX [NC][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   localparam bit ONE_FITS = (FB <= EB - 2);
   localparam logic [EB-1:0] ONE_VAL = ONE_FITS ? (EB'(1) << FB) : {1'b0, {(EB-1){1'b1}}};
   localparam logic ONE_OVF = !ONE_FITS;

   typedef struct packed {
      logic signed [EB-1:0] in_r0c0;
      logic signed [EB-1:0] in_r0c1;
      logic signed [EB-1:0] in_r0c2;
      logic signed [EB-1:0] in_r1c0;
      logic signed [EB-1:0] in_r1c1;
      logic signed [EB-1:0] in_r1c2;
      logic signed [EB-1:0] in_r2c0;
      logic signed [EB-1:0] in_r2c1;
      logic signed [EB-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [EB-1:0] out_r0c0;
      logic signed [EB-1:0] out_r0c1;
      logic signed [EB-1:0] out_r0c2;
      logic signed [EB-1:0] out_r1c0;
      logic signed [EB-1:0] out_r1c1;
      logic signed [EB-1:0] out_r1c2;
      logic signed [EB-1:0] out_r2c0;
      logic signed [EB-1:0] out_r2c1;
      logic signed [EB-1:0] out_r2c2;
      logic                 singular;
      logic signed [EB-1:0] determinant;
      logic                 overflow;
   } rsp_type;

   // one divider stage: nine lanes share the shifted divisor
   typedef struct packed {
      logic [NC-1:0][RW-1:0] rem;
      logic [NC-1:0][QW-1:0] quo;
      logic [NC-1:0]         neg;
      logic [NC-1:0]         sat;
      logic [RW-1:0]         ys;
      logic                  sing;
      logic [EB-1:0]         det;
      logic                  det_ovf;
   } div_type;

endpackage

/* src/m3i_div_step.sv */
// ----------------------------------------------------------------------------
// m3i_div_step
// One restoring-division step: compare, subtract, shift in a quotient bit.
// ----------------------------------------------------------------------------
module m3i_div_step (
   input  logic [m3i_pkg::RW-1:0] rem_i,
   input  logic [m3i_pkg::RW-1:0] ys_i,
   input  logic [m3i_pkg::QW-1:0] quo_i,
   output logic [m3i_pkg::RW-1:0] rem_o,
   output logic [m3i_pkg::QW-1:0] quo_o
);
   import m3i_pkg::*;

   logic ge;

   assign ge    = (rem_i >= ys_i);
   assign rem_o = ge ? (rem_i - ys_i) : rem_i;
   assign quo_o = {quo_i[QW-2:0], ge};

endmodule

/* src/matrix3x3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Streams 3x3 signed Q16.16 matrices and returns the inverse by the adjugate
// method, with the determinant (rounded, saturated) and singular / overflow
// flags. All intermediate values are exact; each inverse element is
// round(C * 2^32 / D), ties away from zero, saturated to 32 bits. A zero
// determinant gives the identity with singular set. One beat is taken every
// clock unless backpressure stalls the pipeline; the 33-step bit-per-stage
// divider (nine lanes sharing one divisor) follows six stages of multiply,
// cofactor, determinant and operand preparation. Backpressure ripples back
// stage by stage, so empty stages keep filling while a result waits.
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  m3i_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output m3i_pkg::rsp_type rsp_data
);
   import m3i_pkg::*;

   localparam int ND = EB + 2;         // precheck stage + QW divide steps
   localparam int NS = 6 + ND + 1;     // total register stages
   localparam int S_DIV = 6;
   localparam int S_OUT = NS - 1;

   // ---- stage control: valid bits and per-stage enables ----
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[S_OUT] = !v_ff[S_OUT] || rsp_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[S_OUT];

   // ---- input elements, row-major ----
   logic signed [EB-1:0] e [NC];
   assign e[0] = req_data.in_r0c0;
   assign e[1] = req_data.in_r0c1;
   assign e[2] = req_data.in_r0c2;
   assign e[3] = req_data.in_r1c0;
   assign e[4] = req_data.in_r1c1;
   assign e[5] = req_data.in_r1c2;
   assign e[6] = req_data.in_r2c0;
   assign e[7] = req_data.in_r2c1;
   assign e[8] = req_data.in_r2c2;

   // ---- stage 0: the eighteen 2x2 products ----
   logic signed [PW-1:0] pp_ff [NC];
   logic signed [PW-1:0] pn_ff [NC];
   logic signed [EB-1:0] r0a_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < NC; k++) begin
            pp_ff[k] <= PW'(e[COF_IDX[k][0]]) * PW'(e[COF_IDX[k][1]]);
            pn_ff[k] <= PW'(e[COF_IDX[k][2]]) * PW'(e[COF_IDX[k][3]]);
         end
         for (int j = 0; j < 3; j++) begin
            r0a_ff[j] <= e[j];
         end
      end
   end

   // ---- stage 1: cofactors ----
   logic signed [CW-1:0] cof1_ff [NC];
   logic signed [EB-1:0] r0b_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < NC; k++) begin
            cof1_ff[k] <= CW'(pp_ff[k]) - CW'(pn_ff[k]);
         end
         r0b_ff <= r0a_ff;
      end
   end

   // ---- stage 2: row 0 times cofactor, split into two narrow multiplies ----
   logic signed [PW+1:0] lo_ff [3];
   logic signed [PW-1:0] hi_ff [3];
   logic signed [CW-1:0] cof2_ff [NC];
   logic signed [EB+1:0] c_lo [3];
   logic signed [EB-1:0] c_hi [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         c_lo[j] = signed'({1'b0, cof1_ff[3*j][EB:0]});
         c_hi[j] = cof1_ff[3*j][CW-1:EB+1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int j = 0; j < 3; j++) begin
            lo_ff[j] <= (PW+2)'(r0b_ff[j]) * (PW+2)'(c_lo[j]);
            hi_ff[j] <= PW'(r0b_ff[j]) * PW'(c_hi[j]);
         end
         cof2_ff <= cof1_ff;
      end
   end

   // ---- stage 3: recombine partial products ----
   logic signed [DW-1:0] term_ff [3];
   logic signed [CW-1:0] cof3_ff [NC];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= (DW'(hi_ff[j]) <<< (EB + 1)) + DW'(lo_ff[j]);
         end
         cof3_ff <= cof2_ff;
      end
   end

   // ---- stage 4: determinant ----
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] cof4_ff [NC];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         cof4_ff <= cof3_ff;
      end
   end

   // ---- stage 5: magnitudes, dividend, determinant output ----
   logic [DW-1:0]   absd;
   logic [DW:0]     drnd;
   logic            d_neg;
   logic            d_sat;
   logic [EB-1:0]   d_val;
   logic [CW-1:0]   absc [NC];

   logic [DW-1:0]         absd_ff;
   logic                  sing_ff;
   logic [EB-1:0]         dout_ff;
   logic                  dovf_ff;
   logic [NC-1:0][RW-1:0] x_ff;
   logic [NC-1:0]         neg_ff;

   always_comb begin
      d_neg = det_ff[DW-1];
      absd  = d_neg ? DW'(-det_ff) : DW'(det_ff);
      drnd  = ((DW+1)'(absd) + ((DW+1)'(1) << (2*FB - 1))) >> (2*FB);
      if (d_neg) begin
         d_sat = (drnd > ((DW+1)'(1) << (EB - 1)));
      end else begin
         d_sat = (drnd > (((DW+1)'(1) << (EB - 1)) - (DW+1)'(1)));
      end
      if (d_sat) begin
         d_val = d_neg ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
      end else begin
         d_val = d_neg ? EB'(-drnd) : drnd[EB-1:0];
      end
      for (int k = 0; k < NC; k++) begin
         absc[k] = cof4_ff[k][CW-1] ? CW'(-cof4_ff[k]) : CW'(cof4_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         absd_ff <= absd;
         sing_ff <= (det_ff == '0);
         dout_ff <= d_val;
         dovf_ff <= d_sat;
         for (int k = 0; k < NC; k++) begin
            // (2|C| * 2^2F + |D|) / (2|D|) gives round-half-away
            x_ff[k]   <= (RW'(absc[k]) << (2*FB + 1)) + RW'(absd);
            neg_ff[k] <= cof4_ff[k][CW-1] ^ d_neg;
         end
      end
   end

   // ---- divider: precheck stage then one quotient bit per stage ----
   div_type       div_ff [ND];
   logic [RW-1:0] y_div;

   assign y_div = RW'(absd_ff) << 1;

   always_ff @(posedge clock) begin
      if (en[S_DIV]) begin
         div_ff[0].rem <= x_ff;
         div_ff[0].quo <= '0;
         div_ff[0].neg <= neg_ff;
         for (int k = 0; k < NC; k++) begin
            // quotient of 2^(EB+1) or more always saturates
            div_ff[0].sat[k] <= (x_ff[k] >= (y_div << (EB + 1)));
         end
         div_ff[0].ys      <= y_div << EB;
         div_ff[0].sing    <= sing_ff;
         div_ff[0].det     <= dout_ff;
         div_ff[0].det_ovf <= dovf_ff;
      end
   end

   for (genvar d = 1; d < ND; d++) begin : g_div
      logic [NC-1:0][RW-1:0] rem_n;
      logic [NC-1:0][QW-1:0] quo_n;

      for (genvar k = 0; k < NC; k++) begin : g_lane
         m3i_div_step u_step (
            .rem_i (div_ff[d-1].rem[k]),
            .ys_i  (div_ff[d-1].ys),
            .quo_i (div_ff[d-1].quo[k]),
            .rem_o (rem_n[k]),
            .quo_o (quo_n[k])
         );
      end

      always_ff @(posedge clock) begin
         if (en[S_DIV + d]) begin
            div_ff[d].rem     <= rem_n;
            div_ff[d].quo     <= quo_n;
            div_ff[d].neg     <= div_ff[d-1].neg;
            div_ff[d].sat     <= div_ff[d-1].sat;
            div_ff[d].ys      <= div_ff[d-1].ys >> 1;
            div_ff[d].sing    <= div_ff[d-1].sing;
            div_ff[d].det     <= div_ff[d-1].det;
            div_ff[d].det_ovf <= div_ff[d-1].det_ovf;
         end
      end
   end

   // ---- output stage: sign, saturate, singular override ----
   localparam logic [QW-1:0] QPOS = (QW'(1) << (EB - 1)) - QW'(1);
   localparam logic [QW-1:0] QNEG = QW'(1) << (EB - 1);

   div_type       dl;
   logic [EB-1:0] res [NC];
   logic [NC-1:0] lane_ovf;
   rsp_type       rsp_in;
   rsp_type       rsp_ff;

   assign dl = div_ff[ND-1];

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         lane_ovf[k] = dl.sat[k] || (dl.neg[k] ? (dl.quo[k] > QNEG) : (dl.quo[k] > QPOS));
         if (lane_ovf[k]) begin
            res[k] = dl.neg[k] ? {1'b1, {(EB-1){1'b0}}} : {1'b0, {(EB-1){1'b1}}};
         end else begin
            res[k] = dl.neg[k] ? EB'(-dl.quo[k]) : dl.quo[k][EB-1:0];
         end
         if (dl.sing) begin
            res[k] = (k % 4 == 0) ? ONE_VAL : '0;
         end
      end
      rsp_in.out_r0c0    = res[0];
      rsp_in.out_r0c1    = res[1];
      rsp_in.out_r0c2    = res[2];
      rsp_in.out_r1c0    = res[3];
      rsp_in.out_r1c1    = res[4];
      rsp_in.out_r1c2    = res[5];
      rsp_in.out_r2c0    = res[6];
      rsp_in.out_r2c1    = res[7];
      rsp_in.out_r2c2    = res[8];
      rsp_in.singular    = dl.sing;
      rsp_in.determinant = dl.sing ? '0 : dl.det;
      rsp_in.overflow    = dl.sing ? ONE_OVF : ((|lane_ovf) || dl.det_ovf);
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---- checks ----
`ifndef NO_ASSERTIONS
   a_stall_only_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v_ff[0])
      else $error("accepted beat lost at first stage");

   a_singular_det_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |-> (rsp_data.determinant == '0))
      else $error("singular result with non-zero determinant");
`endif

endmodule

/* sim/m3i_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// m3i_checker
// Watches both channels of the matrix inverse, predicts each result with
// exact wide integer arithmetic and compares it against the whole response.
// ----------------------------------------------------------------------------
module m3i_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  m3i_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  m3i_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import m3i_pkg::*;

   localparam int WW = 200;
   typedef logic signed [WW-1:0] wide_t;

   rsp_type inverse_queue[$];

   function automatic logic [EB-1:0] saturate(input wide_t v, inout logic ovf);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (EB - 1)) - 1;
      lo = -(wide_t'(1) <<< (EB - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return hi[EB-1:0];
      end
      if (v < lo) begin
         ovf = 1'b1;
         return lo[EB-1:0];
      end
      return v[EB-1:0];
   endfunction

   // nearest, ties away from zero
   function automatic wide_t round_div(input wide_t n, input wide_t d);
      wide_t an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic rsp_type invert(input req_type m);
      wide_t a[NC], c[NC], det;
      logic [EB-1:0] o[NC];
      logic ovf;
      rsp_type r;
      a[0] = wide_t'(m.in_r0c0); a[1] = wide_t'(m.in_r0c1); a[2] = wide_t'(m.in_r0c2);
      a[3] = wide_t'(m.in_r1c0); a[4] = wide_t'(m.in_r1c1); a[5] = wide_t'(m.in_r1c2);
      a[6] = wide_t'(m.in_r2c0); a[7] = wide_t'(m.in_r2c1); a[8] = wide_t'(m.in_r2c2);
      // adjugate, already transposed
      c[0] = a[4]*a[8] - a[5]*a[7]; c[1] = a[2]*a[7] - a[1]*a[8];
      c[2] = a[1]*a[5] - a[2]*a[4]; c[3] = a[5]*a[6] - a[3]*a[8];
      c[4] = a[0]*a[8] - a[2]*a[6]; c[5] = a[2]*a[3] - a[0]*a[5];
      c[6] = a[3]*a[7] - a[4]*a[6]; c[7] = a[1]*a[6] - a[0]*a[7];
      c[8] = a[0]*a[4] - a[1]*a[3];
      det = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
      ovf = 1'b0;
      if (det == 0) begin
         for (int k = 0; k < NC; k++)
            o[k] = (k % 4 == 0) ? saturate(wide_t'(1) <<< FB, ovf) : '0;
         r.singular = 1'b1;
         r.determinant = '0;
      end else begin
         for (int k = 0; k < NC; k++)
            o[k] = saturate(round_div(c[k] <<< (2 * FB), det), ovf);
         r.singular = 1'b0;
         r.determinant = saturate(round_div(det, wide_t'(1) <<< (2 * FB)), ovf);
      end
      r.out_r0c0 = o[0]; r.out_r0c1 = o[1]; r.out_r0c2 = o[2];
      r.out_r1c0 = o[3]; r.out_r1c1 = o[4]; r.out_r1c2 = o[5];
      r.out_r2c0 = o[6]; r.out_r2c1 = o[7]; r.out_r2c2 = o[8];
      r.overflow = ovf;
      return r;
   endfunction

   assign pending = inverse_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) inverse_queue.push_back(invert(req_data));
         if (rsp_valid && rsp_ready) begin
            if (inverse_queue.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = inverse_queue.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* sim/tb_matrix3x3_inverse.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Directed corner matrices then random ones (mostly well conditioned, some
// singular, some extreme) under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;
   import m3i_pkg::*;

   localparam int LATENCY = 41;
   localparam int ONE = 1 << FB;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;

   int      send_idle = 0;     // percent
   int      recv_idle = 0;
   bit      recv_hold = 1'b0;  // long receiver stall

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   matrix3x3_inverse dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   m3i_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending
   );

   // receiver: random idling, overridden by the long hold
   always @(posedge clock)
      rsp_ready <= !reset && !recv_hold && ($urandom_range(99) >= recv_idle);

   function automatic logic [EB-1:0] rnd_elem();
      case ($urandom_range(9))
         0:       return {1'b0, {(EB-1){1'b1}}};
         1:       return {1'b1, {(EB-1){1'b0}}};
         2:       return $urandom;
         3:       return EB'($signed($urandom_range(8))) - 4;
         default: return EB'(int'($urandom_range(8 * ONE)) - 4 * ONE);
      endcase
   endfunction

   function automatic req_type rnd_matrix();
      req_type m;
      logic [NC-1:0][EB-1:0] e;
      for (int k = 0; k < NC; k++) e[k] = rnd_elem();
      // occasionally force a singular one: duplicate or zero a row
      case ($urandom_range(9))
         0: e[5:3] = e[2:0];
         1: e[8:6] = '0;
         default: ;
      endcase
      m = e;
      return m;
   endfunction

   function automatic req_type diag(input logic [EB-1:0] x, y, z);
      req_type m = '0;
      m.in_r0c0 = x; m.in_r1c1 = y; m.in_r2c2 = z;
      return m;
   endfunction

   // one beat; valid stays high across back-to-back beats
   task automatic send(input req_type m);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      req_type m;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send(diag(ONE, ONE, ONE));
      send(diag(2 * ONE, -4 * ONE, ONE / 2));
      send('0);                                   // singular all zero
      send('1);                                   // all minus one lsb
      send({NC{32'h7fffffff}});                   // singular, max
      send({NC{32'h80000000}});
      send(diag(32'h7fffffff, 32'h80000000, 32'h7fffffff));
      send(diag(1, 1, 1));                        // tiny: inverse saturates
      send(diag(1, -1, 1));
      send(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff)); // det saturates
      send(diag(3 * ONE, 3 * ONE, 3 * ONE));      // rounding
      m = diag(ONE, ONE, ONE); m.in_r0c2 = 5 * ONE; m.in_r2c0 = -7 * ONE;
      send(m);
      m = '0; m.in_r0c1 = ONE; m.in_r1c2 = ONE; m.in_r2c0 = ONE;  // permutation
      send(m);
      send('{32'h55555555, 32'haaaaaaaa, 32'h0000ffff, 32'hffff0000, 32'h12345678,
             32'h87654321, 32'h00000001, 32'h7ffffffe, 32'h80000001});
      drain();

      // sender pauses until all results back, then a long receiver stall
      send_idle = 20; recv_idle = 47;
      for (int i = 0; i < 600; i++) send(rnd_matrix());
      drain();
      recv_hold = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int i = 0; i < 100; i++) send(rnd_matrix());
      join
      send_idle = 47; recv_idle = 20;
      for (int i = 0; i < 550; i++) send(rnd_matrix());
      send_idle = 0; recv_idle = 0;
      for (int i = 0; i < 550; i++) send(rnd_matrix());
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* files.f */
src/m3i_pkg.sv
src/m3i_div_step.sv
src/matrix3x3_inverse.sv
sim/m3i_checker.sv
sim/tb_matrix3x3_inverse.sv
